// File: rtl/core/integer_to_ascii_formatter_assert.svh
// Assertion macros shared by the integer to ASCII formatter modules.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, checked on clk, muted while arst_n is low.
`define ITAF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, muted while arst_n is low.
`define ITAF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/itaf_pkg.sv
// Shared constants, types and character helpers of the integer to ASCII formatter.
package itaf_pkg;

	localparam int DIGIT_SLOTS = 21;
	localparam int VALUE_W     = 64;
	localparam int DIG_NIBBLES = 20;
	localparam int DIG_BITS    = DIG_NIBBLES * 4;
	localparam int DABBLE_BITS = 4;
	localparam int CONV_STEPS  = VALUE_W / DABBLE_BITS;
	localparam int STEP_W      = $clog2(CONV_STEPS);
	localparam int LEN_W       = $clog2(DIGIT_SLOTS + 1);
	localparam int IDX_W       = $clog2(DIGIT_SLOTS);
	localparam int NIB_IDX_W   = $clog2(DIG_NIBBLES);

	localparam logic [4:0] WIDTH_LIMIT = 5'd20;

	localparam logic [1:0] MODE_SDEC = 2'd0;
	localparam logic [1:0] MODE_UDEC = 2'd1;
	localparam logic [1:0] MODE_LHEX = 2'd2;
	localparam logic [1:0] MODE_UHEX = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic measure;
		logic emit_sign;
		logic emit_char;
	} itaf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dec;
		logic neg;
		logic idx_zero;
	} itaf_sts_t;

	// Map one nibble to its ASCII digit.
	function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else if (upper) begin
			ch = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end else begin
			ch = CH_LOWER_A + {4'd0, nib} - 8'd10;
		end
		return ch;
	endfunction

endpackage

// File: rtl/core/itaf_ctrl.sv
// Controller state machine of the integer to ASCII formatter.
`include "integer_to_ascii_formatter_assert.svh"

module itaf_ctrl
	import itaf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      num_valid,
	output logic      num_stall,
	output logic      chr_valid,
	input  logic      chr_stall,
	input  itaf_sts_t sts,
	output itaf_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_MEAS = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CONV_STEPS - 1);

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              valid_q, valid_d;
	logic              out_free;

	assign num_stall = (state_q != ST_IDLE);
	assign chr_valid = valid_q;
	assign out_free  = !valid_q || !chr_stall;

	// Sequence load, conversion, measure and one word per free output slot.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		step_d  = step_q;
		valid_d = valid_q && chr_stall;
		case (state_q)
			ST_IDLE: begin
				if (num_valid) begin
					cmd.load = 1'b1;
					step_d   = '0;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (sts.dec) begin
					cmd.step = 1'b1;
					step_d   = step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_d = ST_MEAS;
					end
				end else begin
					state_d = ST_MEAS;
				end
			end
			ST_MEAS: begin
				cmd.measure = 1'b1;
				state_d     = sts.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (out_free) begin
					cmd.emit_sign = 1'b1;
					valid_d       = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit_char = 1'b1;
					valid_d       = 1'b1;
					if (sts.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			valid_q <= valid_d;
		end
	end

	`ITAF_ASSERT_NXT(a_accept_to_conv, num_valid && !num_stall, state_q == ST_CONV, "accept did not start conversion")
	`ITAF_ASSERT_NXT(a_conv_full, state_q == ST_CONV && sts.dec && step_q != STEP_LAST, state_q == ST_CONV, "decimal conversion ended early")
	`ITAF_ASSERT_IMP(a_sign_only_neg, state_q == ST_SIGN, sts.neg, "sign state without negative value")
	`ITAF_ASSERT_IMP(a_no_overwrite, cmd.emit_sign || cmd.emit_char, !valid_q || !chr_stall, "output word overwritten while stalled")

endmodule

// File: rtl/core/itaf_dpath.sv
// Datapath of the integer to ASCII formatter: capture, BCD conversion, measure, output word.
`include "integer_to_ascii_formatter_assert.svh"

module itaf_dpath
	import itaf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         mode,
	input  logic [VALUE_W-1:0] value,
	input  logic [4:0]         field_width,
	input  logic               zero_pad,
	input  itaf_cmd_t          cmd,
	output itaf_sts_t          sts,
	output logic [7:0]         character,
	output logic               last
);

	logic [VALUE_W-1:0]            work_value_q;
	logic [DIG_NIBBLES-1:0][3:0]   digits_q;
	logic [1:0]                    mode_q;
	logic                          neg_q;
	logic                          zpad_q;
	logic [LEN_W-1:0]              width_q;
	logic [LEN_W-1:0]              ndig_q;
	logic [LEN_W-1:0]              total_q;
	logic [IDX_W-1:0]              idx_q;
	logic [7:0]                    char_q;
	logic                          last_q;

	logic                          neg_in;
	logic [VALUE_W-1:0]            mag_in;
	logic [4:0]                    w_sat;
	logic [4:0]                    w_eff;
	logic [DIG_BITS-1:0]           bcd_nx;
	logic [VALUE_W-1:0]            bin_nx;
	logic [LEN_W-1:0]              ndig;
	logic [LEN_W-1:0]              total;
	logic [NIB_IDX_W-1:0]          nib_sel;
	logic [7:0]                    ch_sel;

	assign sts.dec      = (mode_q == MODE_SDEC) || (mode_q == MODE_UDEC);
	assign sts.neg      = neg_q;
	assign sts.idx_zero = (idx_q == '0);
	assign character    = char_q;
	assign last         = last_q;

	// Form magnitude and effective width of the incoming word.
	always_comb begin
		neg_in = (mode == MODE_SDEC) && value[VALUE_W-1];
		mag_in = neg_in ? ({VALUE_W{1'b0}} - value) : value;
		w_sat  = (field_width > WIDTH_LIMIT) ? WIDTH_LIMIT : field_width;
		w_eff  = (neg_in && (w_sat != 5'd0)) ? (w_sat - 5'd1) : w_sat;
	end

	// Advance the double-dabble conversion by four bits.
	always_comb begin
		bcd_nx = digits_q;
		bin_nx = work_value_q;
		for (int s = 0; s < DABBLE_BITS; s++) begin
			for (int d = 0; d < DIG_NIBBLES; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5) begin
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
				end
			end
			{bcd_nx, bin_nx} = {bcd_nx[DIG_BITS-2:0], bin_nx, 1'b0};
		end
	end

	// Count significant digits and the padded length.
	always_comb begin
		ndig = LEN_W'(1);
		for (int d = 0; d < DIG_NIBBLES; d++) begin
			if (digits_q[d] != 4'd0) begin
				ndig = LEN_W'(d + 1);
			end
		end
		total = (ndig > width_q) ? ndig : width_q;
		if (total > LEN_W'(DIGIT_SLOTS)) begin
			total = LEN_W'(DIGIT_SLOTS);
		end
	end

	// Pick the character at the current position: digit or pad.
	always_comb begin
		nib_sel = idx_q[NIB_IDX_W-1:0];
		if (LEN_W'(idx_q) < ndig_q) begin
			ch_sel = sts.dec ? (CH_ZERO + {4'd0, digits_q[nib_sel]})
				: digit_char(digits_q[nib_sel], mode_q == MODE_UHEX);
		end else begin
			ch_sel = zpad_q ? CH_ZERO : CH_SPACE;
		end
	end

	// Load, convert, measure and emit.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q       <= mode;
			neg_q        <= neg_in;
			zpad_q       <= zero_pad;
			width_q      <= LEN_W'(w_eff);
			work_value_q <= mag_in;
			if ((mode == MODE_SDEC) || (mode == MODE_UDEC)) begin
				digits_q <= '0;
			end else begin
				digits_q <= DIG_BITS'(mag_in);
			end
		end
		if (cmd.step) begin
			digits_q     <= bcd_nx;
			work_value_q <= bin_nx;
		end
		if (cmd.measure) begin
			ndig_q  <= ndig;
			total_q <= total;
			idx_q   <= IDX_W'(total - 1'b1);
		end
		if (cmd.emit_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end
		if (cmd.emit_char) begin
			char_q <= ch_sel;
			last_q <= (idx_q == '0);
			idx_q  <= idx_q - 1'b1;
		end
	end

	`ITAF_ASSERT_NXT(a_sign_word, cmd.emit_sign, character == CH_MINUS && !last, "sign word malformed")
	`ITAF_ASSERT_NXT(a_last_word, cmd.emit_char && idx_q == '0, last, "final character not marked last")
	`ITAF_ASSERT_NXT(a_measure_len, cmd.measure, total_q != '0 && idx_q == IDX_W'(total_q - 1'b1), "measured length inconsistent")

endmodule

// File: rtl/core/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: controller plus datapath.
//
//   channel | words             | handshake
//   --------+-------------------+------------------------------
//   number  | mode, value,      | num_valid / num_stall
//           | field_width,      |
//           | zero_pad          |
//   chars   | character, last   | chr_valid / chr_stall
//
// Decimal modes pass through accept, the double-dabble conversion (four bits a cycle),
// measure, then emit the characters (sign included).
// Hex modes skip the conversion.
// A number is taken only while the controller is idle; the final character may
// still wait in the output register. Output stalls hold the word and the sequence.
// Reset clears the controller and the output valid; the datapath needs no reset.
module integer_to_ascii_formatter
	import itaf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               num_valid,
	output logic               num_stall,
	input  logic [1:0]         mode,
	input  logic [VALUE_W-1:0] value,
	input  logic [4:0]         field_width,
	input  logic               zero_pad,
	output logic               chr_valid,
	input  logic               chr_stall,
	output logic [7:0]         character,
	output logic               last
);

	itaf_cmd_t cmd;
	itaf_sts_t sts;

	itaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	itaf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.value       (value),
		.field_width (field_width),
		.zero_pad    (zero_pad),
		.cmd         (cmd),
		.sts         (sts),
		.character   (character),
		.last        (last)
	);

endmodule

// File: tb/integer_to_ascii_formatter_checker.sv
// Checker for the integer to ASCII formatter: predicts every character and compares it.
module integer_to_ascii_formatter_checker
	import itaf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               num_valid,
	input  logic               num_stall,
	input  logic [1:0]         mode,
	input  logic [VALUE_W-1:0] value,
	input  logic [4:0]         field_width,
	input  logic               zero_pad,
	input  logic               chr_valid,
	input  logic               chr_stall,
	input  logic [7:0]         character,
	input  logic               last,
	output int                 mismatches,
	output int                 pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [8*16-1:0] HEX_UPPER = "0123456789ABCDEF";
	localparam logic [8*16-1:0] HEX_LOWER = "0123456789abcdef";

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} ascii_word_t;

	ascii_word_t expected_chars[$];
	int fail_total = 0;
	int pending_total = 0;

	assign mismatches    = fail_total;
	assign pending_words = pending_total;

	// Format one number into its characters and queue them, sign first.
	function automatic void queue_expected_chars(input logic [1:0] m,
			input logic [VALUE_W-1:0] v, input logic [4:0] w, input logic z);
		logic [7:0]         slots [DIGIT_SLOTS];
		logic [VALUE_W-1:0] magnitude;
		logic [3:0]         digit;
		logic [7:0]         ch;
		int                 min_chars;
		int                 used;
		logic               negative;
		magnitude = v;
		min_chars = (w > WIDTH_LIMIT) ? int'(WIDTH_LIMIT) : int'(w);
		negative = 1'b0;
		used = 0;
		// Peel off the sign; it takes one place of the width
		if (m == MODE_SDEC && v[VALUE_W-1]) begin
			negative = 1'b1;
			magnitude = -v;
			if (min_chars > 0) begin
				min_chars = min_chars - 1;
			end
		end
		if (magnitude == '0) begin
			slots[used] = CH_ZERO;
			used = used + 1;
		end
		// Collect digits, least significant first
		while (magnitude != '0) begin
			if (m == MODE_SDEC || m == MODE_UDEC) begin
				digit = 4'(magnitude % 10);
				magnitude = magnitude / 10;
				ch = HEX_UPPER[8*(15-digit) +: 8];
			end else begin
				digit = magnitude[3:0];
				magnitude = magnitude >> 4;
				ch = (m == MODE_UHEX) ? HEX_UPPER[8*(15-digit) +: 8]
					: HEX_LOWER[8*(15-digit) +: 8];
			end
			if (used < DIGIT_SLOTS) begin
				slots[used] = ch;
				used = used + 1;
			end
		end
		// Pad on the left up to the width
		while (used < min_chars && used < DIGIT_SLOTS) begin
			slots[used] = z ? CH_ZERO : CH_SPACE;
			used = used + 1;
		end
		if (negative) begin
			expected_chars.push_back('{ch: CH_MINUS, is_last: 1'b0});
		end
		for (int i = used - 1; i >= 0; i--) begin
			expected_chars.push_back('{ch: slots[i], is_last: (i == 0)});
		end
	endfunction

	// Check the outgoing word first: it can never belong to a number taken at the same edge
	always @(posedge clk) begin
		ascii_word_t want;
		if (arst_n) begin
			if (chr_valid && !chr_stall) begin
				if (expected_chars.size() == 0) begin
					$error("character: unexpected word %h (last %b) with nothing expected",
						character, last);
					fail_total = fail_total + 1;
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.ch) begin
						$error("character: expected %h, got %h", want.ch, character);
						fail_total = fail_total + 1;
					end
					if (last !== want.is_last) begin
						$error("last: expected %b, got %b", want.is_last, last);
						fail_total = fail_total + 1;
					end
				end
			end
			if (num_valid && !num_stall) begin
				queue_expected_chars(mode, value, field_width, zero_pad);
			end
			pending_total = expected_chars.size();
		end
	end

endmodule

// File: tb/tb_integer_to_ascii_formatter.sv
// Testbench top of the integer to ASCII formatter: clock, reset, stimulus and verdict.
module tb_integer_to_ascii_formatter;
	import itaf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};
	localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam int RANDOM_NUMBERS = 270;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               num_valid;
	logic               num_stall;
	logic [1:0]         mode;
	logic [VALUE_W-1:0] value;
	logic [4:0]         field_width;
	logic               zero_pad;
	logic               chr_valid;
	logic               chr_stall = 1'b0;
	logic [7:0]         character;
	logic               last;
	int                 mismatches;
	int                 pending_words;

	int burst_left = 0;
	int stall_style = 0;
	int stall_left = 0;

	integer_to_ascii_formatter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_valid  (num_valid),
		.num_stall  (num_stall),
		.mode       (mode),
		.value      (value),
		.field_width(field_width),
		.zero_pad   (zero_pad),
		.chr_valid  (chr_valid),
		.chr_stall  (chr_stall),
		.character  (character),
		.last       (last)
	);

	integer_to_ascii_formatter_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_valid    (num_valid),
		.num_stall    (num_stall),
		.mode         (mode),
		.value        (value),
		.field_width  (field_width),
		.zero_pad     (zero_pad),
		.chr_valid    (chr_valid),
		.chr_stall    (chr_stall),
		.character    (character),
		.last         (last),
		.mismatches   (mismatches),
		.pending_words(pending_words)
	);

	always #5 clk = ~clk;

	// Stall the character side in stretches: none, light, heavy or solid
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left = $urandom_range(4, 40);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_style)
			0: chr_stall <= 1'b0;
			1: chr_stall <= ($urandom_range(0, 3) == 0);
			2: chr_stall <= ($urandom_range(0, 3) != 0);
			default: chr_stall <= 1'b1;
		endcase
	end

	// Offer one number at a falling edge and hold it until taken; bursts with gaps between
	task automatic send_number(input logic [1:0] m, input logic [VALUE_W-1:0] v,
			input logic [4:0] w, input logic z);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
		end
		burst_left = burst_left - 1;
		if (gap > 0) begin
			num_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		num_valid <= 1'b1;
		mode <= m;
		value <= v;
		field_width <= w;
		zero_pad <= z;
		do @(posedge clk); while (num_stall);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every character has come back
	task automatic drain_chars();
		num_valid <= 1'b0;
		do @(negedge clk); while (pending_words != 0);
	endtask

	// Draw one random number, weighted toward edges and short values
	task automatic send_random_number();
		logic [VALUE_W-1:0] v;
		logic [4:0]         w;
		case ($urandom_range(0, 5))
			0: v = VALUE_W'($urandom_range(0, 99));
			1: v = {$urandom, $urandom};
			2: v = {$urandom, $urandom} >> $urandom_range(1, 63);
			3: v = -VALUE_W'($urandom_range(1, 100000));
			4: v = (VALUE_W'(1) << $urandom_range(0, 63)) - VALUE_W'($urandom_range(0, 1));
			default: v = {$urandom, $urandom} | MOST_NEG;
		endcase
		w = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(21, 31))
			: 5'($urandom_range(0, 20));
		send_number(2'($urandom_range(0, 3)), v, w, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		num_valid = 1'b0;
		mode = MODE_SDEC;
		value = '0;
		field_width = '0;
		zero_pad = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zero, extremes, sign handling, padding and width saturation
		send_number(MODE_SDEC, '0, 5'd0, 1'b0);
		send_number(MODE_UDEC, ALL_ONES, 5'd0, 1'b0);
		send_number(MODE_SDEC, MOST_NEG, 5'd0, 1'b0);
		send_number(MODE_SDEC, MOST_NEG, 5'd20, 1'b1);
		send_number(MODE_SDEC, ALL_ONES, 5'd5, 1'b1);
		send_number(MODE_SDEC, ALL_ONES, 5'd5, 1'b0);
		send_number(MODE_SDEC, -64'd5, 5'd31, 1'b1);
		send_number(MODE_SDEC, MOST_POS, 5'd31, 1'b0);
		send_number(MODE_SDEC, 64'd10, 5'd2, 1'b0);
		send_number(MODE_SDEC, 64'd1, 5'd0, 1'b1);
		send_number(MODE_UDEC, MOST_NEG, 5'd0, 1'b0);
		send_number(MODE_UDEC, '0, 5'd20, 1'b1);
		send_number(MODE_UDEC, 64'd12345, 5'd1, 1'b0);
		send_number(MODE_UDEC, 64'd9, 5'd10, 1'b0);
		send_number(MODE_LHEX, 64'hDEAD_BEEF_0123_ABCD, 5'd0, 1'b0);
		send_number(MODE_UHEX, 64'hDEAD_BEEF_0123_ABCD, 5'd0, 1'b0);
		send_number(MODE_LHEX, ALL_ONES, 5'd16, 1'b1);
		send_number(MODE_UHEX, ALL_ONES, 5'd20, 1'b1);
		send_number(MODE_LHEX, '0, 5'd31, 1'b1);
		send_number(MODE_UHEX, 64'hA, 5'd0, 1'b0);
		send_number(MODE_LHEX, 64'h5A5A, 5'd21, 1'b0);
		drain_chars();

		// Random numbers, with one full drain halfway
		for (int n = 0; n < RANDOM_NUMBERS; n++) begin
			send_random_number();
			if (n == RANDOM_NUMBERS / 2) begin
				drain_chars();
			end
		end

		// Let the last characters out, then give a little extra time for strays
		drain_chars();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && pending_words == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: integer_to_ascii_formatter.f
+incdir+rtl/core
rtl/core/itaf_pkg.sv
rtl/core/itaf_ctrl.sv
rtl/core/itaf_dpath.sv
rtl/core/integer_to_ascii_formatter.sv
tb/integer_to_ascii_formatter_checker.sv
tb/tb_integer_to_ascii_formatter.sv
